### src/mau_pkg.sv
// Shared types and codes for the modular arithmetic unit.
package mau_pkg;

	// operation codes carried in the input transaction
	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_POW = 3'd4;
	localparam logic [2:0] OP_NEG = 3'd5;
	localparam logic [2:0] OP_INV = 3'd6;
	localparam logic [2:0] OP_RED = 3'd7;

	localparam logic [30:0] MODULUS_RESET = 31'd1000000007;

	// datapath micro-operations
	localparam logic [4:0] UOP_NONE      = 5'd0;
	localparam logic [4:0] UOP_LOAD      = 5'd1;
	localparam logic [4:0] UOP_DIV_A     = 5'd2;
	localparam logic [4:0] UOP_DIV_B     = 5'd3;
	localparam logic [4:0] UOP_SAVE_A    = 5'd4;
	localparam logic [4:0] UOP_SAVE_B    = 5'd5;
	localparam logic [4:0] UOP_ALU       = 5'd6;
	localparam logic [4:0] UOP_MUL_AB    = 5'd7;
	localparam logic [4:0] UOP_MUL_ACCB  = 5'd8;
	localparam logic [4:0] UOP_MUL_BB    = 5'd9;
	localparam logic [4:0] UOP_MUL_AACC  = 5'd10;
	localparam logic [4:0] UOP_DIV_PROD  = 5'd11;
	localparam logic [4:0] UOP_SAVE_ACC  = 5'd12;
	localparam logic [4:0] UOP_SAVE_BASE = 5'd13;
	localparam logic [4:0] UOP_POW_INIT  = 5'd14;
	localparam logic [4:0] UOP_SHIFT_K   = 5'd15;
	localparam logic [4:0] UOP_EUC_INITA = 5'd16;
	localparam logic [4:0] UOP_EUC_INITB = 5'd17;
	localparam logic [4:0] UOP_DIV_EUC   = 5'd18;
	localparam logic [4:0] UOP_EUC_MUL   = 5'd19;
	localparam logic [4:0] UOP_EUC_UPD   = 5'd20;
	localparam logic [4:0] UOP_DIV_EU    = 5'd21;
	localparam logic [4:0] UOP_DIV_RAW   = 5'd22;
	localparam logic [4:0] UOP_SAVE_SGN  = 5'd23;
	localparam logic [4:0] UOP_OUT       = 5'd24;

	typedef struct packed {
		logic [4:0] uop;
	} mau_cmd_t;

	typedef struct packed {
		logic       div_busy;
		logic       eb_zero;
		logic       k_zero;
		logic       k_lsb;
		logic       m_small;
		logic       out_busy;
		logic [2:0] op;
	} mau_status_t;

endpackage

### src/mau_div.sv
// Radix-4 restoring divider: 64-bit dividend by 31-bit divisor.
module mau_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [30:0] den,
	output logic        busy,
	output logic [63:0] quot,
	output logic [30:0] rem
);
	logic [63:0] num_q;
	logic [30:0] rem_q;
	logic [30:0] den_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic [31:0] r1, r2;
	logic [30:0] r1s, r2s;
	logic        q1, q0;

	// two dependent compare-subtract steps per cycle
	always_comb begin
		r1  = {rem_q, num_q[63]};
		q1  = (r1 >= {1'b0, den_q});
		r1s = q1 ? 31'(r1 - {1'b0, den_q}) : r1[30:0];
		r2  = {r1s, num_q[62]};
		q0  = (r2 >= {1'b0, den_q});
		r2s = q0 ? 31'(r2 - {1'b0, den_q}) : r2[30:0];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd31) busy_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			num_q <= {num_q[61:0], q1, q0};
			rem_q <= r2s;
		end
	end

	assign busy = busy_q;
	assign quot = num_q;
	assign rem  = rem_q;
endmodule

### src/mau_datapath.sv
// Datapath: operand, power, Euclid and output registers around a shared divider.
module mau_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mau_pkg::mau_cmd_t    cmd,
	output mau_pkg::mau_status_t status,
	input  logic [30:0]          modulus,
	input  logic [199:0]         in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [31:0]          out_data
);
	import mau_pkg::*;

	logic [2:0]  op_q;
	logic [30:0] a_q, b_q, ar_q, br_q, acc_q, base_q;
	logic [63:0] k_q, raw_q;
	logic [61:0] prod_q;
	logic [30:0] ea_q, eb_q;
	logic signed [33:0] eu_q, ev_q, tv_q;
	logic        neg_q;
	logic        ovalid_q;
	logic [31:0] odata_q;

	logic        div_start;
	logic [63:0] div_num;
	logic [30:0] div_den;
	logic        div_busy;
	logic [63:0] div_quot;
	logic [30:0] div_rem;

	logic [30:0] mul_x, mul_y;
	logic [31:0] sum, alu_res;
	logic [63:0] raw_mag;
	logic [33:0] eu_mag;
	logic signed [65:0] tv_full;

	mau_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.busy  (div_busy),
		.quot  (div_quot),
		.rem   (div_rem)
	);

	// divider operand selection
	always_comb begin
		raw_mag   = raw_q[63] ? 64'(64'd0 - raw_q) : raw_q;
		eu_mag    = eu_q[33] ? 34'(-eu_q) : 34'(eu_q);
		div_start = 1'b1;
		div_num   = {33'd0, a_q};
		div_den   = modulus;
		case (cmd.uop)
			UOP_DIV_A:    div_num = {33'd0, a_q};
			UOP_DIV_B:    div_num = {33'd0, b_q};
			UOP_DIV_PROD: div_num = {2'd0, prod_q};
			UOP_DIV_RAW:  div_num = raw_mag;
			UOP_DIV_EU:   div_num = {30'd0, eu_mag};
			UOP_DIV_EUC: begin
				div_num = {33'd0, ea_q};
				div_den = eb_q;
			end
			default:      div_start = 1'b0;
		endcase
	end

	// multiplier operand selection
	always_comb begin
		mul_x = ar_q;
		mul_y = br_q;
		case (cmd.uop)
			UOP_MUL_ACCB: begin mul_x = acc_q;  mul_y = base_q; end
			UOP_MUL_BB:   begin mul_x = base_q; mul_y = base_q; end
			UOP_MUL_AACC: begin mul_x = ar_q;   mul_y = acc_q;  end
			default:      ;
		endcase
	end

	// add, subtract and negate
	always_comb begin
		sum = 32'(ar_q) + 32'(br_q);
		case (op_q)
			OP_ADD:  alu_res = (sum >= 32'(modulus)) ? 32'(sum - 32'(modulus)) : sum;
			OP_SUB:  alu_res = (ar_q >= br_q) ? 32'(ar_q - br_q)
			                                  : 32'(32'(ar_q) + 32'(modulus) - 32'(br_q));
			default: alu_res = (ar_q == '0) ? 32'd0 : 32'(modulus - ar_q);
		endcase
	end

	assign tv_full = $signed({2'b00, div_quot[31:0]}) * ev_q;

	// working registers
	always_ff @(posedge clk) begin
		case (cmd.uop)
			UOP_LOAD: begin
				op_q  <= in_data[2:0];
				a_q   <= in_data[33:3];
				b_q   <= in_data[64:34];
				k_q   <= in_data[128:65];
				raw_q <= in_data[192:129];
				acc_q <= '0;
			end
			UOP_SAVE_A:    ar_q <= div_rem;
			UOP_SAVE_B:    br_q <= div_rem;
			UOP_ALU:       acc_q <= alu_res[30:0];
			UOP_MUL_AB, UOP_MUL_ACCB, UOP_MUL_BB, UOP_MUL_AACC:
			               prod_q <= mul_x * mul_y;
			UOP_SAVE_ACC:  acc_q <= div_rem;
			UOP_SAVE_BASE: base_q <= div_rem;
			UOP_POW_INIT: begin
				acc_q  <= 31'd1;
				base_q <= ar_q;
			end
			UOP_SHIFT_K:   k_q <= {1'b0, k_q[63:1]};
			UOP_EUC_INITA, UOP_EUC_INITB: begin
				ea_q <= (cmd.uop == UOP_EUC_INITA) ? ar_q : br_q;
				eb_q <= modulus;
				eu_q <= 34'sd1;
				ev_q <= 34'sd0;
			end
			UOP_EUC_MUL:   tv_q <= 34'(tv_full);
			UOP_EUC_UPD: begin
				ea_q <= eb_q;
				eb_q <= div_rem;
				eu_q <= ev_q;
				ev_q <= 34'(eu_q - tv_q);
			end
			UOP_DIV_RAW:   neg_q <= raw_q[63];
			UOP_DIV_EU:    neg_q <= eu_q[33];
			UOP_SAVE_SGN:  acc_q <= (neg_q && div_rem != '0) ? 31'(modulus - div_rem)
			                                                : div_rem;
			UOP_OUT: begin
				odata_q[30:0] <= acc_q;
				odata_q[31]   <= (modulus < 31'd2) ? (a_q == b_q) : (ar_q == br_q);
			end
			default: ;
		endcase
	end

	// output register handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ovalid_q <= 1'b0;
		else if (cmd.uop == UOP_OUT) ovalid_q <= 1'b1;
		else if (out_ready) ovalid_q <= 1'b0;
	end

	assign out_valid = ovalid_q;
	assign out_data  = odata_q;

	assign status.div_busy = div_busy;
	assign status.eb_zero  = (eb_q == '0);
	assign status.k_zero   = (k_q == '0);
	assign status.k_lsb    = k_q[0];
	assign status.m_small  = (modulus < 31'd2);
	assign status.out_busy = ovalid_q && !out_ready;
	assign status.op       = op_q;
endmodule

### src/mau_ctrl.sv
// Controller: sequences micro-operations for each operation.
module mau_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  mau_pkg::mau_status_t status,
	output mau_pkg::mau_cmd_t    cmd
);
	import mau_pkg::*;

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_CHK  = 5'd1;
	localparam logic [4:0] S_WA   = 5'd2;
	localparam logic [4:0] S_RB   = 5'd3;
	localparam logic [4:0] S_WB   = 5'd4;
	localparam logic [4:0] S_DISP = 5'd5;
	localparam logic [4:0] S_MR   = 5'd6;
	localparam logic [4:0] S_MW   = 5'd7;
	localparam logic [4:0] S_PLP  = 5'd8;
	localparam logic [4:0] S_PSQ  = 5'd9;
	localparam logic [4:0] S_PSH  = 5'd10;
	localparam logic [4:0] S_EDIV = 5'd11;
	localparam logic [4:0] S_EW   = 5'd12;
	localparam logic [4:0] S_EUP  = 5'd13;
	localparam logic [4:0] S_EUW  = 5'd14;
	localparam logic [4:0] S_DM   = 5'd15;
	localparam logic [4:0] S_RW   = 5'd16;
	localparam logic [4:0] S_OUT  = 5'd17;

	logic [4:0] state_q, state_d;
	logic [4:0] sav_q, sav_d;
	logic [4:0] nxt_q, nxt_d;

	// next state and command
	always_comb begin
		state_d = state_q;
		sav_d   = sav_q;
		nxt_d   = nxt_q;
		cmd.uop = UOP_NONE;
		unique case (state_q)
			S_IDLE: if (in_valid) begin
				cmd.uop = UOP_LOAD;
				state_d = S_CHK;
			end
			S_CHK: begin
				if (status.m_small) state_d = S_OUT;
				else begin
					cmd.uop = UOP_DIV_A;
					state_d = S_WA;
				end
			end
			S_WA: if (!status.div_busy) begin
				cmd.uop = UOP_SAVE_A;
				state_d = S_RB;
			end
			S_RB: begin
				cmd.uop = UOP_DIV_B;
				state_d = S_WB;
			end
			S_WB: if (!status.div_busy) begin
				cmd.uop = UOP_SAVE_B;
				state_d = S_DISP;
			end
			S_DISP: begin
				case (status.op)
					OP_MUL: begin
						cmd.uop = UOP_MUL_AB;
						sav_d   = UOP_SAVE_ACC;
						nxt_d   = S_OUT;
						state_d = S_MR;
					end
					OP_DIV: begin
						cmd.uop = UOP_EUC_INITB;
						state_d = S_EDIV;
					end
					OP_INV: begin
						cmd.uop = UOP_EUC_INITA;
						state_d = S_EDIV;
					end
					OP_POW: begin
						cmd.uop = UOP_POW_INIT;
						state_d = S_PLP;
					end
					OP_RED: begin
						cmd.uop = UOP_DIV_RAW;
						state_d = S_RW;
					end
					default: begin
						cmd.uop = UOP_ALU;
						state_d = S_OUT;
					end
				endcase
			end
			// shared product reduction
			S_MR: begin
				cmd.uop = UOP_DIV_PROD;
				state_d = S_MW;
			end
			S_MW: if (!status.div_busy) begin
				cmd.uop = sav_q;
				state_d = nxt_q;
			end
			// square-and-multiply
			S_PLP: begin
				if (status.k_zero) state_d = S_OUT;
				else if (status.k_lsb) begin
					cmd.uop = UOP_MUL_ACCB;
					sav_d   = UOP_SAVE_ACC;
					nxt_d   = S_PSQ;
					state_d = S_MR;
				end else state_d = S_PSQ;
			end
			S_PSQ: begin
				cmd.uop = UOP_MUL_BB;
				sav_d   = UOP_SAVE_BASE;
				nxt_d   = S_PSH;
				state_d = S_MR;
			end
			S_PSH: begin
				cmd.uop = UOP_SHIFT_K;
				state_d = S_PLP;
			end
			// extended Euclid
			S_EDIV: begin
				if (status.eb_zero) begin
					cmd.uop = UOP_DIV_EU;
					state_d = S_EUW;
				end else begin
					cmd.uop = UOP_DIV_EUC;
					state_d = S_EW;
				end
			end
			S_EW: if (!status.div_busy) begin
				cmd.uop = UOP_EUC_MUL;
				state_d = S_EUP;
			end
			S_EUP: begin
				cmd.uop = UOP_EUC_UPD;
				state_d = S_EDIV;
			end
			S_EUW: if (!status.div_busy) begin
				cmd.uop = UOP_SAVE_SGN;
				state_d = (status.op == OP_DIV) ? S_DM : S_OUT;
			end
			S_DM: begin
				cmd.uop = UOP_MUL_AACC;
				sav_d   = UOP_SAVE_ACC;
				nxt_d   = S_OUT;
				state_d = S_MR;
			end
			S_RW: if (!status.div_busy) begin
				cmd.uop = UOP_SAVE_SGN;
				state_d = S_OUT;
			end
			S_OUT: if (!status.out_busy) begin
				cmd.uop = UOP_OUT;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sav_q   <= UOP_NONE;
			nxt_q   <= S_IDLE;
		end else begin
			state_q <= state_d;
			sav_q   <= sav_d;
			nxt_q   <= nxt_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);
endmodule

### src/modular_arithmetic_unit.sv
// Modular ALU: add, sub, mul, div, pow, negate, inverse and signed reduce.
// pow squares per exponent bit and multiplies per set bit, up to 128 multiplies.
// inverse and div run extended Euclid steps on the divider until the remainder is zero.
// One transaction at a time: input reopens once the result is registered for output.
// Reset: arst_n clears control and loads the modulus with 1000000007.
module modular_arithmetic_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// op[2:0], operand_a[33:3], operand_b[64:34], exponent[128:65],
	// raw_value[192:129], zero pad
	input  logic [199:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// result[30:0], equal[31]
	output logic [31:0]  m_axis_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [30:0]  cfg_data
);
	import mau_pkg::*;

	logic [30:0] modulus_q;
	mau_cmd_t    cmd;
	mau_status_t status;

	// modulus register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) modulus_q <= MODULUS_RESET;
		else if (cfg_valid) modulus_q <= cfg_data;
	end
	assign cfg_ready = 1'b1;

	mau_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.status  (status),
		.cmd     (cmd)
	);

	mau_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.modulus  (modulus_q),
		.in_data  (s_axis_tdata),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data (m_axis_tdata)
	);

	// accepted transaction keeps the input side closed next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted again while working");

	// the divider is never running while new input is taken
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !status.div_busy)
		else $error("divider busy in idle");

	// delivered residue lies below the modulus when the modulus is at least 2
	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && modulus_q >= 31'd2 |-> m_axis_tdata[30:0] < modulus_q)
		else $error("result not reduced");
endmodule

### verif/modular_arithmetic_unit_tb.sv
// Self-checking testbench for the modular arithmetic unit: directed table, random traffic.
module modular_arithmetic_unit_tb;
	import mau_pkg::*;

	localparam int CYCLE_LIMIT = 4000000;
	localparam int DRAIN_CYCLES = 100;
	localparam int ITEMS_PER_PHASE = 20;

	typedef struct {
		logic [2:0]  op;
		logic [30:0] a;
		logic [30:0] b;
		logic [63:0] k;
		logic [63:0] raw;
	} mau_item_t;

	typedef struct packed {
		logic        equal;
		logic [30:0] result;
	} mau_result_t;

	// directed row: item plus an optional typed-in result
	typedef struct {
		logic [2:0]  op;
		logic [30:0] a;
		logic [30:0] b;
		logic [63:0] k;
		logic [63:0] raw;
		bit          known;
		logic [30:0] res;
		logic        eq;
	} dir_row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [199:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [31:0]  m_axis_tdata;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [30:0]  cfg_data = '0;

	logic [30:0]  cur_modulus = MODULUS_RESET;
	mau_result_t  pending_results[$];
	int           error_count = 0;
	int           cycle_count = 0;
	bit           hold_request = 1'b0;

	modular_arithmetic_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// ---------------- predictor ----------------
	function automatic logic [63:0] fold_signed(logic [63:0] raw, logic [63:0] m);
		logic [63:0] r;
		if (!raw[63])
			return raw % m;
		r = (64'd0 - raw) % m;
		return (r == 0) ? 64'd0 : m - r;
	endfunction

	// extended Euclid, truncating division as in signed 64-bit integer math
	function automatic logic [63:0] euclid_inverse(logic [63:0] x, logic [63:0] m);
		longint ea, eb, u, v, t, tmp;
		ea = x;
		eb = m;
		u = 1;
		v = 0;
		while (eb != 0) begin
			t = ea / eb;
			ea = ea - t * eb;
			tmp = ea; ea = eb; eb = tmp;
			u = u - t * v;
			tmp = u; u = v; v = tmp;
		end
		return fold_signed(u, m);
	endfunction

	function automatic logic [63:0] power_mod(logic [63:0] base, logic [63:0] k,
			logic [63:0] m);
		logic [63:0] r;
		r = 64'd1 % m;
		while (k != 0) begin
			if (k[0])
				r = (r * base) % m;
			base = (base * base) % m;
			k = k >> 1;
		end
		return r;
	endfunction

	function automatic mau_result_t calc_residue(mau_item_t it, logic [30:0] modulus);
		logic [63:0] m, a, b, r;
		mau_result_t o;
		m = 64'(modulus);
		a = 64'(it.a);
		b = 64'(it.b);
		if (m < 2) begin
			o.result = '0;
			o.equal = (a == b);
			return o;
		end
		a = a % m;
		b = b % m;
		case (it.op)
			OP_ADD: r = (a + b) % m;
			OP_SUB: r = (a + m - b) % m;
			OP_MUL: r = (a * b) % m;
			OP_DIV: r = (a * euclid_inverse(b, m)) % m;
			OP_POW: r = power_mod(a, it.k, m);
			OP_NEG: r = (a == 0) ? 64'd0 : m - a;
			OP_INV: r = euclid_inverse(a, m);
			default: r = fold_signed(it.raw, m);
		endcase
		o.result = r[30:0];
		o.equal = (a == b);
		return o;
	endfunction

	// ---------------- mismatch report ----------------
	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want,
			cycle_count);
		error_count++;
	endtask

	// ---------------- result side ----------------
	always @(posedge clk) begin
		mau_result_t got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected transaction", 64'(got.result), 64'd0);
			end else begin
				want = pending_results.pop_front();
				if (got.result !== want.result)
					report_mismatch("result", 64'(got.result), 64'(want.result));
				if (got.equal !== want.equal)
					report_mismatch("equal", 64'(got.equal), 64'(want.equal));
			end
		end
	end

	// receiver backpressure, with one long hold-off on request
	initial begin
		int r;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				m_axis_tready <= 1'b0;
				repeat (3000) @(negedge clk);
				hold_request = 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 60)
					m_axis_tready <= 1'b1;
				else if (r < 97)
					m_axis_tready <= 1'b0;
				else begin
					m_axis_tready <= 1'b0;
					repeat ($urandom_range(20, 80)) @(negedge clk);
				end
			end
		end
	end

	// ---------------- stimulus side ----------------
	task automatic send_item(mau_item_t it, bit known, mau_result_t typed);
		mau_result_t want;
		int gap;
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'd0, it.raw, it.k, it.b, it.a, it.op};
		do @(posedge clk); while (!s_axis_tready);
		want = calc_residue(it, cur_modulus);
		if (known && want != typed)
			report_mismatch("predictor vs table", 64'(want.result), 64'(typed.result));
		pending_results.push_back(known ? typed : want);
		// gap: mostly none or short, now and then long
		gap = ($urandom_range(0, 9) < 4) ? 0 :
			($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
		if (gap > 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_modulus(logic [30:0] value);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cur_modulus = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [30:0] pick_operand(logic [30:0] m);
		case ($urandom_range(0, 5))
			0: return 31'd0;
			1: return 31'(m - 31'd1);
			2: return 31'h7FFF_FFFE;
			3: return 31'($urandom_range(0, 31));
			default: return 31'($urandom() & 32'h7FFF_FFFF);
		endcase
	endfunction

	function automatic mau_item_t random_item(logic [30:0] m);
		mau_item_t it;
		longint n;
		it.op = 3'($urandom_range(0, 7));
		it.a = pick_operand(m);
		it.b = ($urandom_range(0, 7) == 0) ? it.a : pick_operand(m);
		if (it.a == 31'h7FFF_FFFF) it.a = 31'h7FFF_FFFE;
		if (it.b == 31'h7FFF_FFFF) it.b = 31'h7FFF_FFFE;
		case ($urandom_range(0, 3))
			0: it.k = 64'($urandom_range(0, 20));
			1: it.k = {32'd0, $urandom()};
			default: it.k = {$urandom(), $urandom()};
		endcase
		case ($urandom_range(0, 4))
			0: begin
				n = longint'($urandom_range(1, 1000));
				it.raw = -(longint'(m) * n);
			end
			1: it.raw = $urandom_range(0, 1) ? 64'h8000_0000_0000_0000
				: 64'h7FFF_FFFF_FFFF_FFFF;
			default: it.raw = {$urandom(), $urandom()};
		endcase
		return it;
	endfunction

	// directed rows, run at the reset modulus
	dir_row_t directed_rows [20] = '{
		'{OP_ADD, 31'd0, 31'd0, 64'd0, 64'd0, 1'b1, 31'd0, 1'b1},
		'{OP_ADD, 31'd1000000006, 31'd1000000006, 64'd0, 64'd0, 1'b0, 31'd0, 1'b0},
		'{OP_SUB, 31'd0, 31'd1, 64'd0, 64'd0, 1'b1, 31'd1000000006, 1'b0},
		'{OP_MUL, 31'h7FFF_FFFE, 31'h7FFF_FFFE, 64'd0, 64'd0, 1'b0, 31'd0, 1'b0},
		'{OP_DIV, 31'd5, 31'd0, 64'd0, 64'd0, 1'b1, 31'd0, 1'b0},
		'{OP_DIV, 31'd6, 31'd3, 64'd0, 64'd0, 1'b0, 31'd0, 1'b0},
		'{OP_POW, 31'd0, 31'd0, 64'd0, 64'd0, 1'b1, 31'd1, 1'b1},
		'{OP_POW, 31'd2, 31'd5, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 1'b0, 31'd0, 1'b0},
		'{OP_POW, 31'h7FFF_FFFE, 31'd0, 64'd1000000005, 64'd0, 1'b0, 31'd0, 1'b0},
		'{OP_NEG, 31'd0, 31'd0, 64'd0, 64'd0, 1'b1, 31'd0, 1'b1},
		'{OP_NEG, 31'd1, 31'd0, 64'd0, 64'd0, 1'b1, 31'd1000000006, 1'b0},
		'{OP_INV, 31'd0, 31'd9, 64'd0, 64'd0, 1'b1, 31'd0, 1'b0},
		'{OP_INV, 31'd1, 31'd9, 64'd0, 64'd0, 1'b1, 31'd1, 1'b0},
		'{OP_INV, 31'd2, 31'd9, 64'd0, 64'd0, 1'b0, 31'd0, 1'b0},
		// negative exact multiple folds to zero
		'{OP_RED, 31'd0, 31'd0, 64'd0, 64'hFFFF_FFFF_C465_35F9, 1'b1, 31'd0, 1'b1},
		'{OP_RED, 31'd0, 31'd0, 64'd0, 64'h8000_0000_0000_0000, 1'b0, 31'd0, 1'b0},
		'{OP_RED, 31'd0, 31'd0, 64'd0, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 31'd0, 1'b0},
		'{OP_RED, 31'd0, 31'd0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 31'd1000000006, 1'b1},
		'{OP_RED, 31'd3, 31'd4, 64'd0, 64'd0, 1'b1, 31'd0, 1'b0},
		// operands above the modulus that reduce to the same residue
		'{OP_ADD, 31'h7FFF_FFFE, 31'd1147483639, 64'd0, 64'd0, 1'b0, 31'd0, 1'b0}
	};

	logic [30:0] phase_moduli [6] = '{31'd2, 31'h7FFF_FFFF, 31'd7, MODULUS_RESET,
		31'd65521, 31'd0};

	initial begin
		mau_item_t it;
		mau_result_t typed;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			it = '{directed_rows[i].op, directed_rows[i].a, directed_rows[i].b,
				directed_rows[i].k, directed_rows[i].raw};
			typed = '{directed_rows[i].eq, directed_rows[i].res};
			send_item(it, directed_rows[i].known, typed);
		end

		// random phases, each at its own modulus; sender pauses until drained
		phase_moduli[5] = 31'($urandom_range(3, 32'h7FFF_FFFF));
		foreach (phase_moduli[p]) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			wait_drained();
			write_modulus(phase_moduli[p]);
			if (p == 1)
				hold_request = 1'b1;
			repeat (ITEMS_PER_PHASE)
				send_item(random_item(cur_modulus), 1'b0, '0);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b0;

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			error_count++;
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

### files.f
src/mau_pkg.sv
src/mau_div.sv
src/mau_datapath.sv
src/mau_ctrl.sv
src/modular_arithmetic_unit.sv
verif/modular_arithmetic_unit_tb.sv
